/* sv/mpfb_pkg.sv */
// Shared opcodes, colour modes and defaults for the page framebuffer draw engine.
`timescale 1ns / 1ps
package mpfb_pkg;

   // Default screen geometry.
   localparam int DEF_SCREEN_WIDTH = 128;
   localparam int DEF_SCREEN_PAGES = 8;

   // Command opcodes.
   localparam logic [2:0] OP_POINT  = 3'd0;
   localparam logic [2:0] OP_LINE   = 3'd1;
   localparam logic [2:0] OP_CIRCLE = 3'd2;
   localparam logic [2:0] OP_SPAN   = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;
   localparam logic [2:0] OP_READ   = 3'd5;

   // Colour modes.
   localparam logic [1:0] COL_NONE   = 2'd0;
   localparam logic [1:0] COL_CLEAR  = 2'd1;
   localparam logic [1:0] COL_SET    = 2'd2;
   localparam logic [1:0] COL_INVERT = 2'd3;

endpackage

/* sv/mpfb_ram.sv */
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module mpfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One access per cycle; read data appears on the next edge.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

/* sv/mono_page_framebuffer_draw_engine.sv */
// Top level of the monochrome page framebuffer draw engine.
`timescale 1ns / 1ps
// The engine holds a 1-bit-per-pixel display store of SCREEN_PAGES pages by
// SCREEN_WIDTH columns, one byte per column and page, and runs one command
// at a time: point, vertical or horizontal line, circle, page span fill,
// clear all, and byte read. Every command returns exactly one beat, and a new
// command is taken in the cycle after that beat leaves. After reset the engine
// sweeps the store to zero, one byte per cycle, before the first command
// is accepted; clear all takes the same sweep. Each drawn pixel or span byte
// is a read-modify-write (S_PIX_RD, then S_PIX_WR) through the single RAM
// port, and an off-screen one is skipped after S_PIX_RD. Circle steps share
// the one squaring unit and the RAM port. A read passes through S_RD_ISS and
// S_RD_WAIT before it offers its beat.
module mono_page_framebuffer_draw_engine #(
   parameter int SCREEN_WIDTH = mpfb_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_PAGES = mpfb_pkg::DEF_SCREEN_PAGES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_opcode,
   input  logic [7:0] req_x_pos,
   input  logic [7:0] req_y_pos,
   input  logic [7:0] req_x_end,
   input  logic [7:0] req_y_end,
   input  logic [7:0] req_radius,
   input  logic [2:0] req_page,
   input  logic [1:0] req_color,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic [2:0] rsp_done_opcode
);
   import mpfb_pkg::*;

   localparam int DEPTH  = SCREEN_WIDTH * SCREEN_PAGES;
   localparam int ADDR_W = $clog2(DEPTH);

   // Sequencer states.
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CLR     = 4'd1;
   localparam logic [3:0] S_LINE    = 4'd2;
   localparam logic [3:0] S_SPAN    = 4'd3;
   localparam logic [3:0] S_CIR_R2  = 4'd4;
   localparam logic [3:0] S_CIR_SQB = 4'd5;
   localparam logic [3:0] S_CIR_CMP = 4'd6;
   localparam logic [3:0] S_CIR_PT  = 4'd7;
   localparam logic [3:0] S_CIR_SQA = 4'd8;
   localparam logic [3:0] S_CIR_DEC = 4'd9;
   localparam logic [3:0] S_PIX_RD  = 4'd10;
   localparam logic [3:0] S_PIX_WR  = 4'd11;
   localparam logic [3:0] S_RD_ISS  = 4'd12;
   localparam logic [3:0] S_RD_WAIT = 4'd13;
   localparam logic [3:0] S_RESP    = 4'd14;

   logic [3:0]        state_ff, state_in;
   logic              boot_ff, boot_in;
   logic [2:0]        op_ff, op_in;
   logic [7:0]        x_ff, x_in, y_ff, y_in;
   logic [7:0]        rad_ff, rad_in;
   logic [2:0]        pg_ff, pg_in;
   logic [1:0]        col_ff, col_in;
   logic [7:0]        cur_ff, cur_in, lim_ff, lim_in;
   logic              vert_ff, vert_in;
   logic [7:0]        px_ff, px_in, py_ff, py_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [3:0]        k_ff, k_in;
   logic [8:0]        a_ff, a_in, b_ff, b_in;
   logic [15:0]       r2_ff, r2_in, bb_ff, bb_in;
   logic [17:0]       prod_ff;
   logic [8:0]        mul_op;
   logic [7:0]        data_ff, data_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [7:0]        ram_wdata, ram_rdata;

   logic [3:0]        ret_state;
   logic [4:0]        pix_pg;
   logic              pix_on;
   logic [ADDR_W-1:0] pix_addr;
   logic [7:0]        bit_mask;
   logic [7:0]        ca, cb;

   mpfb_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   // Pixel address, visibility and bit position.
   assign pix_pg   = py_ff[7:3];
   assign pix_on   = ({1'b0, px_ff} < 9'(SCREEN_WIDTH)) &&
                     ({1'b0, pix_pg} < 6'(SCREEN_PAGES)) && (col_ff != COL_NONE);
   assign pix_addr = ADDR_W'(32'(pix_pg) * 32'(SCREEN_WIDTH) + 32'(px_ff));
   assign bit_mask = 8'd1 << py_ff[2:0];
   assign ca       = a_ff[7:0];
   assign cb       = b_ff[7:0];

   // Where a finished pixel hands control back.
   always_comb begin
      unique case (op_ff)
         OP_LINE:   ret_state = S_LINE;
         OP_CIRCLE: ret_state = S_CIR_PT;
         OP_SPAN:   ret_state = S_SPAN;
         default:   ret_state = S_RESP;
      endcase
   end

   // Shared squaring unit operand.
   always_comb begin
      unique case (state_ff)
         S_CIR_R2:  mul_op = {1'b0, rad_ff};
         S_CIR_SQA: mul_op = a_ff + 9'd1;
         default:   mul_op = b_ff;
      endcase
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in  = state_ff;
      boot_in   = boot_ff;
      op_in     = op_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      rad_in    = rad_ff;
      pg_in     = pg_ff;
      col_in    = col_ff;
      cur_in    = cur_ff;
      lim_in    = lim_ff;
      vert_in   = vert_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      addr_in   = addr_ff;
      clr_in    = clr_ff;
      k_in      = k_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      r2_in     = r2_ff;
      bb_in     = bb_ff;
      data_in   = data_ff;
      ram_we    = 1'b0;
      ram_addr  = pix_addr;
      ram_wdata = 8'h00;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in   = req_opcode;
               x_in    = req_x_pos;
               y_in    = req_y_pos;
               rad_in  = req_radius;
               pg_in   = req_page;
               col_in  = req_color;
               data_in = 8'h00;
               unique case (req_opcode)
                  OP_POINT: begin
                     px_in    = req_x_pos;
                     py_in    = req_y_pos;
                     state_in = S_PIX_RD;
                  end
                  OP_LINE: begin
                     if (req_x_pos == req_x_end) begin
                        vert_in  = 1'b1;
                        cur_in   = req_y_pos;
                        lim_in   = req_y_end;
                        state_in = S_LINE;
                     end else if (req_y_pos == req_y_end) begin
                        vert_in  = 1'b0;
                        cur_in   = req_x_pos;
                        lim_in   = req_x_end;
                        state_in = S_LINE;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  OP_CIRCLE: begin
                     a_in     = 9'd0;
                     b_in     = {1'b0, req_radius};
                     state_in = S_CIR_R2;
                  end
                  OP_SPAN: begin
                     cur_in   = req_x_pos;
                     lim_in   = req_x_end;
                     state_in = S_SPAN;
                  end
                  OP_CLEAR: begin
                     clr_in   = '0;
                     state_in = S_CLR;
                  end
                  OP_READ: begin
                     px_in = req_x_pos;
                     py_in = {2'b00, req_page, 3'b000};
                     if (({3'b000, req_page} < 6'(SCREEN_PAGES)) &&
                         ({1'b0, req_x_pos} < 9'(SCREEN_WIDTH))) begin
                        state_in = S_RD_ISS;
                     end else begin
                        state_in = S_RESP;
                     end
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_CLR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
            clr_in   = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               boot_in  = 1'b0;
               state_in = boot_ff ? S_IDLE : S_RESP;
            end
         end
         S_LINE: begin
            if (cur_ff < lim_ff) begin
               px_in    = vert_ff ? x_ff : cur_ff;
               py_in    = vert_ff ? cur_ff : y_ff;
               cur_in   = cur_ff + 8'd1;
               state_in = S_PIX_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SPAN: begin
            if ((cur_ff < lim_ff) && ({1'b0, cur_ff} < 9'(SCREEN_WIDTH))) begin
               px_in    = cur_ff;
               py_in    = {2'b00, pg_ff, 3'b000};
               cur_in   = cur_ff + 8'd1;
               state_in = S_PIX_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_CIR_R2: begin
            state_in = S_CIR_SQB;
         end
         S_CIR_SQB: begin
            if (op_ff == OP_CIRCLE && a_ff == 9'd0 && b_ff == {1'b0, rad_ff}) begin
               r2_in = prod_ff[15:0];
            end
            state_in = S_CIR_CMP;
         end
         S_CIR_CMP: begin
            bb_in = prod_ff[15:0];
            if ({prod_ff, 1'b0} >= {3'b000, r2_ff}) begin
               k_in     = 4'd0;
               state_in = S_CIR_PT;
            end else begin
               state_in = S_RESP;
            end
         end
         S_CIR_PT: begin
            if (k_ff == 4'd8) begin
               state_in = S_CIR_SQA;
            end else begin
               unique case (k_ff[2:0])
                  3'd0: begin px_in = x_ff + ca; py_in = y_ff - cb; end
                  3'd1: begin px_in = x_ff - ca; py_in = y_ff - cb; end
                  3'd2: begin px_in = x_ff - ca; py_in = y_ff + cb; end
                  3'd3: begin px_in = x_ff + ca; py_in = y_ff + cb; end
                  3'd4: begin px_in = x_ff + cb; py_in = y_ff + ca; end
                  3'd5: begin px_in = x_ff + cb; py_in = y_ff - ca; end
                  3'd6: begin px_in = x_ff - cb; py_in = y_ff - ca; end
                  default: begin px_in = x_ff - cb; py_in = y_ff + ca; end
               endcase
               k_in     = k_ff + 4'd1;
               state_in = S_PIX_RD;
            end
         end
         S_CIR_SQA: begin
            state_in = S_CIR_DEC;
         end
         S_CIR_DEC: begin
            // Step outside the circle: pull b in and keep a.
            if (19'(prod_ff) + 19'(bb_ff) > 19'(r2_ff)) begin
               b_in     = b_ff - 9'd1;
               state_in = (b_ff == 9'd0) ? S_RESP : S_CIR_SQB;
            end else begin
               a_in     = a_ff + 9'd1;
               state_in = S_CIR_SQB;
            end
         end
         S_PIX_RD: begin
            if (pix_on) begin
               addr_in  = pix_addr;
               state_in = S_PIX_WR;
            end else begin
               state_in = ret_state;
            end
         end
         S_PIX_WR: begin
            ram_we   = 1'b1;
            ram_addr = addr_ff;
            if (op_ff == OP_SPAN) begin
               unique case (col_ff)
                  COL_CLEAR:  ram_wdata = 8'h00;
                  COL_SET:    ram_wdata = 8'hFF;
                  COL_INVERT: ram_wdata = ~ram_rdata;
                  default:    ram_wdata = ram_rdata;
               endcase
            end else begin
               unique case (col_ff)
                  COL_CLEAR:  ram_wdata = ram_rdata & ~bit_mask;
                  COL_SET:    ram_wdata = ram_rdata | bit_mask;
                  COL_INVERT: ram_wdata = ram_rdata ^ bit_mask;
                  default:    ram_wdata = ram_rdata;
               endcase
            end
            state_in = ret_state;
         end
         S_RD_ISS: begin
            state_in = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            data_in  = ram_rdata;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state resets; payload registers just load.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         boot_ff  <= 1'b1;
         clr_ff   <= '0;
         a_ff     <= 9'd0;
         b_ff     <= 9'd0;
      end else begin
         state_ff <= state_in;
         boot_ff  <= boot_in;
         clr_ff   <= clr_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
      end
      op_ff   <= op_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      rad_ff  <= rad_in;
      pg_ff   <= pg_in;
      col_ff  <= col_in;
      cur_ff  <= cur_in;
      lim_ff  <= lim_in;
      vert_ff <= vert_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      addr_ff <= addr_in;
      k_ff    <= k_in;
      r2_ff   <= r2_in;
      bb_ff   <= bb_in;
      data_ff <= data_in;
      prod_ff <= 18'(mul_op) * 18'(mul_op);
   end

   // Ports.
   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_RESP);
   assign rsp_read_data   = data_ff;
   assign rsp_done_opcode = op_ff;

`ifndef SYNTHESIS
   // The store is never written while the engine waits for a command.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !ram_we)
      else $error("store written while idle");

   // A result beat is only offered while new commands are held off.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("result offered while accepting commands");

   // A write-back always follows its own read.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PIX_WR) |-> ($past(state_ff) == S_PIX_RD))
      else $error("write-back without read");

   // An accepted command holds off the next one until it has finished.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("command accepted while busy");
`endif

endmodule

/* test/tb_mono_page_framebuffer_draw_engine.sv */
// Self-checking testbench for the page framebuffer draw engine: directed and random commands.
`timescale 1ns / 1ps
module tb_mono_page_framebuffer_draw_engine;
   import mpfb_pkg::*;

   localparam int         WIDTH       = DEF_SCREEN_WIDTH;
   localparam int         PAGES       = DEF_SCREEN_PAGES;
   localparam int         CYCLE_LIMIT = 5000000;
   localparam int         TAIL_CYCLES = 200;
   localparam logic [2:0] OP_SPARE_6  = 3'd6;
   localparam logic [2:0] OP_SPARE_7  = 3'd7;

   typedef struct packed {
      logic [7:0] read_data;
      logic [2:0] done_opcode;
   } done_beat_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_opcode;
   logic [7:0] req_x_pos;
   logic [7:0] req_y_pos;
   logic [7:0] req_x_end;
   logic [7:0] req_y_end;
   logic [7:0] req_radius;
   logic [2:0] req_page;
   logic [1:0] req_color;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_read_data;
   logic [2:0] rsp_done_opcode;

   // Model of the display store and the queue of beats still owed by the engine.
   logic [7:0]    pixel_bytes [WIDTH*PAGES];
   done_beat_type pending_beats [$];
   bit            failed = 1'b0;
   bit            steady;
   int            rsp_hold = 0;
   longint        cycle_count = 0;

   mono_page_framebuffer_draw_engine u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_x_pos      (req_x_pos),
      .req_y_pos      (req_y_pos),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_radius     (req_radius),
      .req_page       (req_page),
      .req_color      (req_color),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_done_opcode(rsp_done_opcode)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Pixel update after wrapping both coordinates to 8 bits.
   function automatic void paint_pixel(int x, int y, logic [1:0] color);
      logic [7:0] col;
      logic [7:0] row;
      int         idx;
      col = 8'(x);
      row = 8'(y);
      if (col >= WIDTH || (row >> 3) >= PAGES) return;
      idx = (row >> 3) * WIDTH + col;
      case (color)
         COL_CLEAR:  pixel_bytes[idx] &= ~(8'd1 << row[2:0]);
         COL_SET:    pixel_bytes[idx] |= (8'd1 << row[2:0]);
         COL_INVERT: pixel_bytes[idx] ^= (8'd1 << row[2:0]);
         default: ;
      endcase
   endfunction

   // Midpoint-style circle with eight-way symmetry, as the engine steps it.
   function automatic void paint_circle(int x, int y, int r, logic [1:0] color);
      int a;
      int b;
      int r2;
      a  = 0;
      b  = r;
      r2 = r * r;
      while (b >= 0 && 2 * b * b >= r2) begin
         paint_pixel(x + a, y - b, color);
         paint_pixel(x - a, y - b, color);
         paint_pixel(x - a, y + b, color);
         paint_pixel(x + a, y + b, color);
         paint_pixel(x + b, y + a, color);
         paint_pixel(x + b, y - a, color);
         paint_pixel(x - b, y - a, color);
         paint_pixel(x - b, y + a, color);
         a++;
         if (a * a + b * b - r2 > 0) begin
            b--;
            a--;
         end
      end
   endfunction

   // Applies one accepted command to the store model and returns the beat it owes.
   function automatic done_beat_type execute_command(logic [2:0] op, int xp, int yp, int xe,
                                                     int ye, int rad, int pg,
                                                     logic [1:0] color);
      done_beat_type beat;
      beat.read_data   = 8'd0;
      beat.done_opcode = op;
      case (op)
         OP_POINT: paint_pixel(xp, yp, color);
         OP_LINE: begin
            if (xp == xe) begin
               for (int i = 0; yp + i < ye; i++) paint_pixel(xp, yp + i, color);
            end else if (yp == ye) begin
               for (int i = 0; xp + i < xe; i++) paint_pixel(xp + i, yp, color);
            end
         end
         OP_CIRCLE: paint_circle(xp, yp, rad, color);
         OP_SPAN: begin
            if (pg < PAGES) begin
               for (int x = xp; x < xe && x < WIDTH; x++) begin
                  case (color)
                     COL_CLEAR:  pixel_bytes[pg*WIDTH+x] = 8'h00;
                     COL_SET:    pixel_bytes[pg*WIDTH+x] = 8'hFF;
                     COL_INVERT: pixel_bytes[pg*WIDTH+x] = ~pixel_bytes[pg*WIDTH+x];
                     default: ;
                  endcase
               end
            end
         end
         OP_CLEAR: foreach (pixel_bytes[i]) pixel_bytes[i] = 8'h00;
         OP_READ: begin
            if (pg < PAGES && xp < WIDTH) beat.read_data = pixel_bytes[pg*WIDTH+xp];
         end
         default: ;
      endcase
      return beat;
   endfunction

   // Sends one command beat after a random gap and records what it must return.
   task automatic send_command(logic [2:0] op, logic [7:0] xp, logic [7:0] yp,
                               logic [7:0] xe, logic [7:0] ye, logic [7:0] rad,
                               logic [2:0] pg, logic [1:0] color);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 18);
      repeat (gap) @(negedge clock) req_valid <= 1'b0;
      @(negedge clock);
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_x_pos  <= xp;
      req_y_pos  <= yp;
      req_x_end  <= xe;
      req_y_end  <= ye;
      req_radius <= rad;
      req_page   <= pg;
      req_color  <= color;
      do @(posedge clock); while (!(req_valid && !req_stall));
      pending_beats.push_back(execute_command(op, xp, yp, xe, ye, rad, pg, color));
   endtask

   task automatic read_byte(logic [2:0] pg, logic [7:0] col);
      send_command(OP_READ, col, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   pg, 2'($urandom));
   endtask

   // Withdraws the last beat, then waits until the engine has answered everything.
   task automatic drain_pending();
      @(negedge clock) req_valid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
   endtask

   task automatic test_points();
      send_command(OP_POINT, 8'd0, 8'd0, 0, 0, 0, 0, COL_SET);
      send_command(OP_POINT, 8'd127, 8'd63, 0, 0, 0, 0, COL_INVERT);
      send_command(OP_POINT, 8'd200, 8'd255, 0, 0, 0, 0, COL_SET);
      send_command(OP_POINT, 8'd0, 8'd0, 0, 0, 0, 0, COL_NONE);
      read_byte(3'd0, 8'd0);
      send_command(OP_POINT, 8'd0, 8'd0, 0, 0, 0, 0, COL_CLEAR);
      read_byte(3'd7, 8'd127);
   endtask

   task automatic test_lines();
      send_command(OP_LINE, 8'd5, 8'd3, 8'd5, 8'd60, 0, 0, COL_SET);
      send_command(OP_LINE, 8'd100, 8'd9, 8'd255, 8'd9, 0, 0, COL_INVERT);
      send_command(OP_LINE, 8'd9, 8'd40, 8'd2, 8'd40, 0, 0, COL_SET);
      send_command(OP_LINE, 8'd1, 8'd1, 8'd30, 8'd30, 0, 0, COL_SET);
      read_byte(3'd1, 8'd5);
      read_byte(3'd1, 8'd120);
   endtask

   task automatic test_circles();
      send_command(OP_CIRCLE, 8'd64, 8'd32, 0, 0, 8'd0, 0, COL_INVERT);
      send_command(OP_CIRCLE, 8'd10, 8'd250, 0, 0, 8'd20, 0, COL_SET);
      send_command(OP_CIRCLE, 8'd255, 8'd255, 0, 0, 8'd255, 0, COL_INVERT);
      read_byte(3'd4, 8'd64);
   endtask

   task automatic test_spans();
      send_command(OP_SPAN, 8'd0, 0, 8'd255, 0, 0, 3'd7, COL_SET);
      send_command(OP_SPAN, 8'd120, 0, 8'd130, 0, 0, 3'd2, COL_INVERT);
      send_command(OP_SPAN, 8'd50, 0, 8'd50, 0, 0, 3'd3, COL_SET);
      send_command(OP_SPAN, 8'd10, 0, 8'd20, 0, 0, 3'd7, COL_CLEAR);
      send_command(OP_SPAN, 8'd0, 0, 8'd40, 0, 0, 3'd2, COL_NONE);
      read_byte(3'd2, 8'd125);
   endtask

   task automatic test_clear_and_spare();
      read_byte(3'd2, 8'd200);
      send_command(OP_SPARE_6, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 3'($urandom), 2'($urandom));
      send_command(OP_SPARE_7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7, COL_INVERT);
      send_command(OP_CLEAR, 0, 0, 0, 0, 0, 0, COL_NONE);
      read_byte(3'd7, 8'd0);
   endtask

   // Random commands, biased toward drawable shapes and frequent read-back.
   task automatic test_random(int count);
      int          pick;
      logic [7:0]  xp;
      logic [7:0]  yp;
      logic [7:0]  xe;
      logic [7:0]  ye;
      logic [7:0]  rad;
      logic [2:0]  op;
      for (int n = 0; n < count; n++) begin
         if (n % 60 == 0) steady = ($urandom_range(0, 3) == 0);
         if (n == count / 2) drain_pending();
         pick = $urandom_range(0, 99);
         xp   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
         yp   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 63));
         xe   = 8'($urandom);
         ye   = 8'($urandom);
         rad  = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
         if (pick < 35) op = OP_READ;
         else if (pick < 55) op = OP_POINT;
         else if (pick < 70) op = OP_LINE;
         else if (pick < 80) op = OP_CIRCLE;
         else if (pick < 92) op = OP_SPAN;
         else if (pick < 95) op = OP_CLEAR;
         else op = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
         // Most lines are straight so that they actually draw.
         if (op == OP_LINE) begin
            case ($urandom_range(0, 4))
               0, 1: xe = xp;
               2, 3: ye = yp;
               default: ;
            endcase
         end
         send_command(op, xp, yp, xe, ye, rad, 3'($urandom), 2'($urandom));
      end
      steady = 1'b0;
   endtask

   // Result side: random stall, then each beat checked against the oldest expectation.
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= (rsp_hold > 0);
   end

   always @(posedge clock) begin
      done_beat_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_beats.size() == 0) begin
               $error("unexpected beat: read_data %0h done_opcode %0d", rsp_read_data,
                      rsp_done_opcode);
               failed = 1'b1;
            end else begin
               want = pending_beats.pop_front();
               if (rsp_read_data !== want.read_data) begin
                  $error("read_data expected %0h actual %0h", want.read_data, rsp_read_data);
                  failed = 1'b1;
               end
               if (rsp_done_opcode !== want.done_opcode) begin
                  $error("done_opcode expected %0d actual %0d", want.done_opcode,
                         rsp_done_opcode);
                  failed = 1'b1;
               end
            end
            rsp_hold = steady ? 0 : $urandom_range(0, 18);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      steady      = 1'b0;
      foreach (pixel_bytes[i]) pixel_bytes[i] = 8'h00;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_opcode = OP_POINT;
      req_x_pos  = 8'd0;
      req_y_pos  = 8'd0;
      req_x_end  = 8'd0;
      req_y_end  = 8'd0;
      req_radius = 8'd0;
      req_page   = 3'd0;
      req_color  = COL_NONE;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      test_points();
      test_lines();
      test_circles();
      test_spans();
      test_clear_and_spare();
      test_random(520);

      @(negedge clock) req_valid <= 1'b0;
      drain_pending();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (!failed) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* files.f */
sv/mpfb_pkg.sv
sv/mpfb_ram.sv
sv/mono_page_framebuffer_draw_engine.sv
test/tb_mono_page_framebuffer_draw_engine.sv
